// ----- src/dlnm_pkg.sv -----
// Shared types and constants of the dense layer neuron MAC.
// No dependencies; every other file refers to it by scoped names.
package dlnm_pkg;

  localparam int DATA_W = 16;
  localparam int ACC_W = 32;
  localparam int SUM_W = ACC_W + 1;
  localparam int SHIFT_W = 4;
  localparam int IDX_W = 10;
  localparam int PORT_LANES = 4;
  localparam int LANE_COUNT_DEF = 4;
  localparam int MAX_NEURONS = 1024;
  localparam int MAX_NEURONS_W = 13;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RST = 4'd8;
  localparam logic signed [SUM_W-1:0] SAT_HI = 33'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_LO = -33'sd32768;
  localparam logic signed [DATA_W-1:0] OUT_HI = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] OUT_LO = 16'sh8000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAC_SHIFT  = 8'd0,
    REG_RELU_ENABLE = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] act_a;
    logic signed [DATA_W-1:0] act_b;
    logic signed [DATA_W-1:0] act_c;
    logic signed [DATA_W-1:0] act_d;
    logic signed [DATA_W-1:0] wt_a;
    logic signed [DATA_W-1:0] wt_b;
    logic signed [DATA_W-1:0] wt_c;
    logic signed [DATA_W-1:0] wt_d;
    logic signed [DATA_W-1:0] neuron_bias;
    logic                     row_end;
    logic                     layer_end;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] neuron_out;
    logic [IDX_W-1:0]         neuron_index;
    logic                     clipped;
    logic                     last_neuron;
  } result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] bias;
    logic                     row_end;
    logic                     layer_end;
  } prod_ctrl_t;

endpackage

// ----- src/dense_layer_neuron_mac.sv -----
// Top level of the dense layer neuron MAC: configuration registers and the two stages.
// Depends on dlnm_pkg, dlnm_mult and dlnm_acc.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries four activation and weight
//   pairs, the neuron bias and the row_end/layer_end marks.
//   result channel (result_valid/result_ready/result) carries one neuron per
//   row_end item: saturated output, its index, the clip flag and last_neuron.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes frac_shift
//   (index 0) and relu_enable (index 1); cfg_ready is always high, other
//   indexes are ignored; write only while the block is idle.
// Timing:
//   an item is registered in the input register, its lane products in the
//   product register, and a row_end item then loads the result register.
//   One item is taken per cycle while item_ready is high; the accumulator loop
//   closes through the acc register so consecutive items need no spacing.
// Reset (rst, synchronous): clears the accumulator, the neuron index and all
//   valid flags; frac_shift returns to 8 and relu_enable to 0.
// Stall: while a result waits, items without row_end keep flowing; a row_end
//   item holds in the product stage and back-pressure reaches item_ready.
module dense_layer_neuron_mac #(
  parameter int LANE_COUNT = dlnm_pkg::LANE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  dlnm_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output dlnm_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dlnm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dlnm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ActiveLanes = (LANE_COUNT < dlnm_pkg::PORT_LANES) ?
                               LANE_COUNT : dlnm_pkg::PORT_LANES;

  logic [dlnm_pkg::SHIFT_W-1:0]         frac_shift;
  logic                                 relu_enable;
  logic                                 prod_valid;
  logic                                 prod_ready;
  logic signed [dlnm_pkg::ACC_W-1:0]    prods [ActiveLanes];
  dlnm_pkg::prod_ctrl_t                 prod_ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_shift  <= dlnm_pkg::FRAC_SHIFT_RST;
      relu_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dlnm_pkg::REG_FRAC_SHIFT:  frac_shift  <= cfg_data[dlnm_pkg::SHIFT_W-1:0];
        dlnm_pkg::REG_RELU_ENABLE: relu_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dlnm_mult #(
    .LANE_COUNT (LANE_COUNT)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prods      (prods),
    .prod_ctrl  (prod_ctrl)
  );

  dlnm_acc #(
    .ActiveLanes (ActiveLanes)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .frac_shift   (frac_shift),
    .relu_enable  (relu_enable),
    .prod_valid   (prod_valid),
    .prod_ready   (prod_ready),
    .prods        (prods),
    .prod_ctrl    (prod_ctrl),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- src/dlnm_mult.sv -----
// Input register and lane product register of the dense layer neuron MAC.
// Depends on dlnm_pkg.
module dlnm_mult #(
  parameter int LANE_COUNT = dlnm_pkg::LANE_COUNT_DEF,
  localparam int ActiveLanes = (LANE_COUNT < dlnm_pkg::PORT_LANES) ?
                               LANE_COUNT : dlnm_pkg::PORT_LANES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  dlnm_pkg::item_t                      item,
  output logic                                 prod_valid,
  input  logic                                 prod_ready,
  output logic signed [dlnm_pkg::ACC_W-1:0]    prods [ActiveLanes],
  output dlnm_pkg::prod_ctrl_t                 prod_ctrl
);

  logic                                 in_valid;
  dlnm_pkg::item_t                      in_item;
  logic                                 prod_free;
  logic signed [dlnm_pkg::DATA_W-1:0]   acts [dlnm_pkg::PORT_LANES];
  logic signed [dlnm_pkg::DATA_W-1:0]   wts [dlnm_pkg::PORT_LANES];
  logic signed [dlnm_pkg::ACC_W-1:0]    prods_next [ActiveLanes];

  assign prod_free  = !prod_valid || prod_ready;
  assign item_ready = !in_valid || prod_free;

  always_comb begin
    acts[0] = in_item.act_a;
    acts[1] = in_item.act_b;
    acts[2] = in_item.act_c;
    acts[3] = in_item.act_d;
    wts[0]  = in_item.wt_a;
    wts[1]  = in_item.wt_b;
    wts[2]  = in_item.wt_c;
    wts[3]  = in_item.wt_d;
    for (int l = 0; l < ActiveLanes; l++) begin
      prods_next[l] = acts[l] * wts[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      in_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_free) begin
      prod_valid <= in_valid;
    end
    if (prod_free && in_valid) begin
      prods               <= prods_next;
      prod_ctrl.bias      <= in_item.neuron_bias;
      prod_ctrl.row_end   <= in_item.row_end;
      prod_ctrl.layer_end <= in_item.layer_end;
    end
  end

endmodule

// ----- src/dlnm_acc.sv -----
// Accumulator, row-end scaling, bias, saturation, ReLU and result register.
// Depends on dlnm_pkg.
module dlnm_acc #(
  parameter int ActiveLanes = dlnm_pkg::LANE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [dlnm_pkg::SHIFT_W-1:0]         frac_shift,
  input  logic                                 relu_enable,
  input  logic                                 prod_valid,
  output logic                                 prod_ready,
  input  logic signed [dlnm_pkg::ACC_W-1:0]    prods [ActiveLanes],
  input  dlnm_pkg::prod_ctrl_t                 prod_ctrl,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output dlnm_pkg::result_t                    result
);

  logic [dlnm_pkg::ACC_W-1:0]           acc;
  logic [dlnm_pkg::ACC_W-1:0]           acc_sum;
  logic [dlnm_pkg::IDX_W-1:0]           counter;
  logic [dlnm_pkg::IDX_W-1:0]           counter_next;
  logic [dlnm_pkg::IDX_W:0]             counter_inc;
  logic signed [dlnm_pkg::ACC_W-1:0]    shifted;
  logic signed [dlnm_pkg::SUM_W-1:0]    biased;
  logic signed [dlnm_pkg::DATA_W-1:0]   sat_val;
  logic                                 sat_clip;
  logic signed [dlnm_pkg::DATA_W-1:0]   out_val;
  logic                                 take;
  logic                                 emit;

  assign prod_ready = !prod_ctrl.row_end || !result_valid || result_ready;
  assign take       = prod_valid && prod_ready;
  assign emit       = take && prod_ctrl.row_end;

  always_comb begin
    acc_sum = acc;
    for (int l = 0; l < ActiveLanes; l++) begin
      acc_sum = acc_sum + $unsigned(prods[l]);
    end
  end

  assign shifted = $signed(acc_sum) >>> frac_shift;
  assign biased  = dlnm_pkg::SUM_W'(shifted) + dlnm_pkg::SUM_W'(prod_ctrl.bias);

  always_comb begin
    if (biased > dlnm_pkg::SAT_HI) begin
      sat_val  = dlnm_pkg::OUT_HI;
      sat_clip = 1'b1;
    end else if (biased < dlnm_pkg::SAT_LO) begin
      sat_val  = dlnm_pkg::OUT_LO;
      sat_clip = 1'b1;
    end else begin
      sat_val  = biased[dlnm_pkg::DATA_W-1:0];
      sat_clip = 1'b0;
    end
    out_val = (relu_enable && sat_val < 0) ? '0 : sat_val;
  end

  always_comb begin
    counter_inc = {1'b0, counter} + 1'b1;
    if ({2'b00, counter_inc} >= dlnm_pkg::MAX_NEURONS_W'(dlnm_pkg::MAX_NEURONS)) begin
      counter_next = '0;
    end else begin
      counter_next = counter_inc[dlnm_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      counter      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (take) begin
        if (prod_ctrl.row_end) begin
          acc     <= '0;
          counter <= prod_ctrl.layer_end ? '0 : counter_next;
        end else begin
          acc <= acc_sum;
        end
      end
    end
    if (emit) begin
      result.neuron_out   <= out_val;
      result.neuron_index <= counter;
      result.clipped      <= sat_clip;
      result.last_neuron  <= prod_ctrl.layer_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> result_valid)
    else $error("row end item did not load the result register");

  a_row_end_clears_acc: assert property (@(posedge clk) disable iff (rst)
    emit |=> acc == '0)
    else $error("accumulator not cleared after row end");

  a_layer_end_resets_index: assert property (@(posedge clk) disable iff (rst)
    emit && prod_ctrl.layer_end |=> counter == '0)
    else $error("neuron index not reset after layer end");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clipped |->
      result.neuron_out == dlnm_pkg::OUT_HI || result.neuron_out == dlnm_pkg::OUT_LO ||
      result.neuron_out == '0)
    else $error("clipped result holds an unsaturated value");
`endif

endmodule
